### rtl/core/gpw_pkg.sv
// Shared types, constants and the 5x7 font table of the glyph pixel writer.
// No dependencies; every other file of the block imports this package.
package gpw_pkg;

   localparam int DEF_GLYPH_WIDTH  = 5;
   localparam int DEF_GLYPH_HEIGHT = 7;

   localparam int OFFSET_W   = 26;
   localparam int DIM_W      = 13;
   localparam int COORD_W    = 12;
   localparam int CODE_W     = 8;
   localparam int COLOUR_W   = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int ROM_ADDR_W = 11;
   localparam int ROM_ROW_W  = 5;
   localparam int FONT_ROWS  = 413;
   localparam int FONT_IDX_W = 9;

   // A character never produces more writes than a default glyph has cells.
   localparam int MAX_WRITES = 35;
   localparam int WR_COUNT_W = 6;

   localparam int unsigned BYTES_PER_PIXEL = 3;

   typedef logic [CODE_W-1:0]     char_code_type;
   typedef logic [COORD_W-1:0]    coord_type;
   typedef logic [DIM_W-1:0]      dim_type;
   typedef logic [COLOUR_W-1:0]   colour_type;
   typedef logic [OFFSET_W-1:0]   offset_type;
   typedef logic [CSR_IDX_W-1:0]  csr_index_type;
   typedef logic [ROM_ADDR_W-1:0] rom_addr_type;
   typedef logic [ROM_ROW_W-1:0]  rom_row_type;

   localparam char_code_type FIRST_CODE = 8'd32;
   localparam char_code_type LAST_CODE  = 8'd126;

   localparam csr_index_type CSR_IMAGE_WIDTH  = 3'd0;
   localparam csr_index_type CSR_IMAGE_HEIGHT = 3'd1;
   localparam csr_index_type CSR_INK_RED      = 3'd2;
   localparam csr_index_type CSR_INK_GREEN    = 3'd3;
   localparam csr_index_type CSR_INK_BLUE     = 3'd4;

   localparam dim_type    RESET_WIDTH  = 13'd640;
   localparam dim_type    RESET_HEIGHT = 13'd480;
   localparam colour_type RESET_INK    = 8'd255;

   // Seven rows per glyph for codes 32 to 90; codes above that are blank.
   localparam rom_row_type FONT [0:FONT_ROWS-1] = '{
      5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00, 5'h04,5'h04,5'h04,5'h04,5'h00,5'h00,5'h04,
      5'h0A,5'h0A,5'h0A,5'h00,5'h00,5'h00,5'h00, 5'h0A,5'h0A,5'h1F,5'h0A,5'h1F,5'h0A,5'h0A,
      5'h04,5'h0F,5'h14,5'h0E,5'h05,5'h1E,5'h04, 5'h18,5'h19,5'h02,5'h04,5'h08,5'h13,5'h03,
      5'h0C,5'h12,5'h14,5'h08,5'h15,5'h12,5'h0D, 5'h0C,5'h04,5'h08,5'h00,5'h00,5'h00,5'h00,
      5'h02,5'h04,5'h08,5'h08,5'h08,5'h04,5'h02, 5'h08,5'h04,5'h02,5'h02,5'h02,5'h04,5'h08,
      5'h00,5'h0A,5'h04,5'h1F,5'h04,5'h0A,5'h00, 5'h00,5'h04,5'h04,5'h1F,5'h04,5'h04,5'h00,
      5'h00,5'h00,5'h00,5'h0C,5'h04,5'h08,5'h00, 5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00,5'h00,
      5'h00,5'h00,5'h00,5'h00,5'h00,5'h0C,5'h0C, 5'h01,5'h02,5'h04,5'h08,5'h10,5'h00,5'h00,
      5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E, 5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E,
      5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F, 5'h1F,5'h02,5'h04,5'h02,5'h01,5'h11,5'h0E,
      5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02, 5'h1F,5'h10,5'h1E,5'h01,5'h01,5'h11,5'h0E,
      5'h06,5'h08,5'h10,5'h1E,5'h11,5'h11,5'h0E, 5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08,
      5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E, 5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h02,5'h0C,
      5'h00,5'h0C,5'h0C,5'h00,5'h0C,5'h0C,5'h00, 5'h00,5'h0C,5'h0C,5'h00,5'h0C,5'h04,5'h08,
      5'h02,5'h04,5'h08,5'h10,5'h08,5'h04,5'h02, 5'h00,5'h00,5'h1F,5'h00,5'h1F,5'h00,5'h00,
      5'h08,5'h04,5'h02,5'h01,5'h02,5'h04,5'h08, 5'h0E,5'h11,5'h01,5'h02,5'h00,5'h04,5'h04,
      5'h0E,5'h11,5'h17,5'h15,5'h17,5'h10,5'h0E, 5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11,
      5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E, 5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E,
      5'h1C,5'h12,5'h11,5'h11,5'h11,5'h12,5'h1C, 5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F,
      5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10, 5'h0E,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0E,
      5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11, 5'h0E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E,
      5'h07,5'h02,5'h02,5'h02,5'h02,5'h12,5'h0C, 5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11,
      5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F, 5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11,
      5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h11, 5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E,
      5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10, 5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D,
      5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11, 5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E,
      5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04, 5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E,
      5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04, 5'h11,5'h11,5'h11,5'h15,5'h15,5'h1B,5'h11,
      5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11, 5'h11,5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,
      5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F
   };

   // Rows past the drawn part of the font, and past the ROM itself, read as blank.
   function automatic rom_row_type glyph_row(input rom_addr_type addr);
      rom_row_type row;
      row = '0;
      if (addr < ROM_ADDR_W'(FONT_ROWS)) begin
         row = FONT[addr[FONT_IDX_W-1:0]];
      end
      return row;
   endfunction

endpackage

### rtl/core/gpw_if.sv
// Handshake channels of the glyph pixel writer: request, response and register write.
// Depends on gpw_pkg for the field types.
interface gpw_req_if import gpw_pkg::*; ();
   logic          valid;
   logic          ready;
   char_code_type char_code;
   coord_type     origin_x;
   coord_type     origin_y;

   modport source (output valid, char_code, origin_x, origin_y, input ready);
   modport sink   (input valid, char_code, origin_x, origin_y, output ready);
endinterface

interface gpw_rsp_if import gpw_pkg::*; ();
   logic       valid;
   logic       ready;
   offset_type byte_offset;
   colour_type red;
   colour_type green;
   colour_type blue;
   logic       last_pixel;

   modport source (output valid, byte_offset, red, green, blue, last_pixel, input ready);
   modport sink   (input valid, byte_offset, red, green, blue, last_pixel, output ready);
endinterface

interface gpw_csr_if import gpw_pkg::*; ();
   logic          valid;
   logic          ready;
   csr_index_type wr_index;
   dim_type       wr_data;

   modport source (output valid, wr_index, wr_data, input ready);
   modport sink   (input valid, wr_index, wr_data, output ready);
endinterface

### rtl/core/gpw_glyph_rom.sv
// Font ROM of the glyph pixel writer with a registered read port.
// Depends on gpw_pkg for the font table and the address and row types.
module gpw_glyph_rom import gpw_pkg::*; (
   input  logic         clock,
   input  logic         rd_en,
   input  rom_addr_type rd_addr,
   output rom_row_type  rd_data
);

   rom_row_type data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_ff <= glyph_row(rd_addr);
      end
   end

   assign rd_data = data_ff;

endmodule

### rtl/core/glyph_pixel_writer.sv
// Top level of the glyph pixel writer: sequencer, address stepping and registers.
// Depends on gpw_pkg, the channel interfaces in gpw_if and gpw_glyph_rom.
//
//   channel  direction  beat carries
//   req_if   in         char_code, origin_x, origin_y
//   rsp_if   out        byte_offset, red, green, blue, last_pixel
//   csr_if   in         wr_index, wr_data (register write)
//
// A drawable character passes from its request beat through ST_IDLE (accepting), ST_MUL
// (multiply), ST_LIN (add origin), ST_ROW (scale by three), ST_CELL for each glyph cell
// and ST_FLUSH to release the last write. Codes outside 32 to 126 finish in the accepting
// cycle. Each write beat is held back until the next lit cell so that the final one can
// carry last_pixel; a stalled response port stops the cell scan. Synchronous reset
// restores the register defaults; the font ROM needs no clearing.
module glyph_pixel_writer import gpw_pkg::*; #(
   parameter int GLYPH_WIDTH  = DEF_GLYPH_WIDTH,
   parameter int GLYPH_HEIGHT = DEF_GLYPH_HEIGHT
) (
   input logic        clock,
   input logic        reset,
   gpw_req_if.sink    req_if,
   gpw_rsp_if.source  rsp_if,
   gpw_csr_if.sink    csr_if
);

   localparam int COL_W = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;
   localparam int ROW_W = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MUL   = 6'b000010,
      ST_LIN   = 6'b000100,
      ST_ROW   = 6'b001000,
      ST_CELL  = 6'b010000,
      ST_FLUSH = 6'b100000
   } state_type;

   state_type    st_ff, st_in;
   rom_addr_type rom_base_ff, rom_base_in;
   coord_type    ox_ff, ox_in, oy_ff, oy_in;
   offset_type   mult_ff, mult_in, lin_ff, lin_in;
   offset_type   row_off_ff, row_off_in, cell_off_ff, cell_off_in;
   logic [14:0]  width3_ff, width3_in;
   dim_type      px_ff, px_in, py_ff, py_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [WR_COUNT_W-1:0] wr_count_ff, wr_count_in;
   logic         pend_valid_ff, pend_valid_in;
   offset_type   pend_off_ff, pend_off_in;
   logic         rsp_valid_ff, rsp_valid_in;
   offset_type   rsp_off_ff, rsp_off_in;
   logic         rsp_last_ff, rsp_last_in;
   colour_type   rsp_red_ff, rsp_red_in, rsp_green_ff, rsp_green_in;
   colour_type   rsp_blue_ff, rsp_blue_in;
   dim_type      width_ff, width_in, height_ff, height_in;
   colour_type   red_ff, red_in, green_ff, green_in, blue_ff, blue_in;

   logic         rom_rd_en;
   rom_addr_type rom_rd_addr;
   rom_row_type  rom_data;
   logic [7:0]   row_wide;
   logic [2:0]   bit_sel;
   logic [24:0]  prod;
   logic         hit, out_free, cell_stall, push, push_last;
   offset_type   push_off;

   gpw_glyph_rom u_rom (
      .clock   (clock),
      .rd_en   (rom_rd_en),
      .rd_addr (rom_rd_addr),
      .rd_data (rom_data)
   );

   assign req_if.ready       = (st_ff == ST_IDLE);
   assign csr_if.ready       = 1'b1;
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.byte_offset = rsp_off_ff;
   assign rsp_if.red         = rsp_red_ff;
   assign rsp_if.green       = rsp_green_ff;
   assign rsp_if.blue        = rsp_blue_ff;
   assign rsp_if.last_pixel  = rsp_last_ff;

   // The leftmost pixel sits in the most significant bit of a font row.
   assign row_wide = 8'(rom_data);
   assign bit_sel  = 3'(GLYPH_WIDTH - 1) - 3'(col_ff);
   assign prod     = oy_ff * width_ff;
   // Lit cells past the write limit of a character are dropped.
   assign hit      = row_wide[bit_sel] && (px_ff < width_ff) && (py_ff < height_ff)
                   && (wr_count_ff < WR_COUNT_W'(MAX_WRITES));
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign cell_stall = (st_ff == ST_CELL) && hit && pend_valid_ff && !out_free;
   assign rom_rd_addr = rom_base_ff + ROM_ADDR_W'(row_ff)
                      + ((st_ff == ST_CELL) ? ROM_ADDR_W'(1) : ROM_ADDR_W'(0));

   always_comb begin
      st_in         = st_ff;
      rom_base_in   = rom_base_ff;
      ox_in         = ox_ff;
      oy_in         = oy_ff;
      mult_in       = mult_ff;
      lin_in        = lin_ff;
      row_off_in    = row_off_ff;
      cell_off_in   = cell_off_ff;
      width3_in     = width3_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      wr_count_in   = wr_count_ff;
      pend_valid_in = pend_valid_ff;
      pend_off_in   = pend_off_ff;
      rom_rd_en     = 1'b0;
      push          = 1'b0;
      push_last     = 1'b0;
      push_off      = pend_off_ff;

      unique case (st_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               if (req_if.char_code >= FIRST_CODE && req_if.char_code <= LAST_CODE) begin
                  st_in = ST_MUL;
               end
               rom_base_in = ROM_ADDR_W'((req_if.char_code - FIRST_CODE) * GLYPH_HEIGHT);
               ox_in  = req_if.origin_x;
               oy_in  = req_if.origin_y;
               col_in = '0;
               row_in = '0;
               wr_count_in = '0;
            end
         end
         ST_MUL: begin
            mult_in   = OFFSET_W'(prod);
            width3_in = 15'(width_ff * BYTES_PER_PIXEL);
            rom_rd_en = 1'b1;
            px_in     = DIM_W'(ox_ff);
            py_in     = DIM_W'(oy_ff);
            st_in     = ST_LIN;
         end
         ST_LIN: begin
            lin_in = mult_ff + OFFSET_W'(ox_ff);
            st_in  = ST_ROW;
         end
         ST_ROW: begin
            row_off_in  = lin_ff + {lin_ff[OFFSET_W-2:0], 1'b0};
            cell_off_in = lin_ff + {lin_ff[OFFSET_W-2:0], 1'b0};
            st_in       = ST_CELL;
         end
         ST_CELL: begin
            if (!cell_stall) begin
               if (hit) begin
                  push          = pend_valid_ff;
                  pend_valid_in = 1'b1;
                  pend_off_in   = cell_off_ff;
                  wr_count_in   = wr_count_ff + WR_COUNT_W'(1);
               end
               if (col_ff == COL_W'(GLYPH_WIDTH - 1)) begin
                  col_in      = '0;
                  px_in       = DIM_W'(ox_ff);
                  py_in       = py_ff + DIM_W'(1);
                  row_off_in  = row_off_ff + OFFSET_W'(width3_ff);
                  cell_off_in = row_off_ff + OFFSET_W'(width3_ff);
                  rom_rd_en   = 1'b1;
                  if (row_ff == ROW_W'(GLYPH_HEIGHT - 1)) begin
                     st_in = ST_FLUSH;
                  end else begin
                     row_in = row_ff + ROW_W'(1);
                  end
               end else begin
                  col_in      = col_ff + COL_W'(1);
                  px_in       = px_ff + DIM_W'(1);
                  cell_off_in = cell_off_ff + OFFSET_W'(BYTES_PER_PIXEL);
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               st_in = ST_IDLE;
            end else if (out_free) begin
               push          = 1'b1;
               push_last     = 1'b1;
               pend_valid_in = 1'b0;
               st_in         = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_off_in   = rsp_off_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_red_in   = rsp_red_ff;
      rsp_green_in = rsp_green_ff;
      rsp_blue_in  = rsp_blue_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_off_in   = push_off;
         rsp_last_in  = push_last;
         rsp_red_in   = red_ff;
         rsp_green_in = green_ff;
         rsp_blue_in  = blue_ff;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      red_in    = red_ff;
      green_in  = green_ff;
      blue_in   = blue_ff;
      if (csr_if.valid) begin
         unique case (csr_if.wr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_if.wr_data;
            CSR_IMAGE_HEIGHT: height_in = csr_if.wr_data;
            CSR_INK_RED:      red_in    = csr_if.wr_data[COLOUR_W-1:0];
            CSR_INK_GREEN:    green_in  = csr_if.wr_data[COLOUR_W-1:0];
            CSR_INK_BLUE:     blue_in   = csr_if.wr_data[COLOUR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         width_ff      <= RESET_WIDTH;
         height_ff     <= RESET_HEIGHT;
         red_ff        <= RESET_INK;
         green_ff      <= RESET_INK;
         blue_ff       <= RESET_INK;
      end else begin
         st_ff         <= st_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         red_ff        <= red_in;
         green_ff      <= green_in;
         blue_ff       <= blue_in;
      end
   end

   always_ff @(posedge clock) begin
      rom_base_ff  <= rom_base_in;
      ox_ff        <= ox_in;
      oy_ff        <= oy_in;
      mult_ff      <= mult_in;
      lin_ff       <= lin_in;
      row_off_ff   <= row_off_in;
      cell_off_ff  <= cell_off_in;
      width3_ff    <= width3_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      wr_count_ff  <= wr_count_in;
      pend_off_ff  <= pend_off_in;
      rsp_off_ff   <= rsp_off_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_red_ff   <= rsp_red_in;
      rsp_green_ff <= rsp_green_in;
      rsp_blue_ff  <= rsp_blue_in;
   end

`ifndef NO_ASSERTIONS
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("held-back write left behind when the character finished");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      push |-> (!rsp_valid_ff || rsp_if.ready))
      else $error("new write loaded over a response beat not yet taken");

   a_stall_holds_scan: assert property (@(posedge clock) disable iff (reset)
      cell_stall |=> (st_ff == ST_CELL) && $stable(col_ff) && $stable(row_ff))
      else $error("cell scan moved on while the response port was stalled");
`endif

endmodule
